@@ hw/rtl/twis_pkg.sv @@
// shared types, codes and constants of the touch wake i2c sequencer
package twis_pkg;

    // transfer slot pool
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_EXT_W = SLOT_IDX_W + 3;

    // result buffer holds every result of one event
    localparam int RES_DEPTH = 3;

    // sequence step of a slot
    typedef enum logic [2:0] {
        STEP_EN0    = 3'd0,
        STEP_EN1    = 3'd1,
        STEP_EN2    = 3'd2,
        STEP_DIS0   = 3'd3,
        STEP_INT0   = 3'd4,
        STEP_INT1   = 3'd5,
        STEP_IDLE   = 3'd6,
        STEP_CANCEL = 3'd7
    } step_t;

    // result kinds
    typedef enum logic [3:0] {
        KIND_WRITE   = 4'd0,
        KIND_WRRD    = 4'd1,
        KIND_TIMER   = 4'd2,
        KIND_TAP     = 4'd3,
        KIND_ON      = 4'd4,
        KIND_OFF     = 4'd5,
        KIND_REFUSED = 4'd6,
        KIND_GAVEUP  = 4'd7,
        KIND_CANCEL  = 4'd8
    } kind_t;

    // event codes
    typedef enum logic [2:0] {
        FUNC_POWER_ON  = 3'd0,
        FUNC_POWER_OFF = 3'd1,
        FUNC_TOUCH     = 3'd2,
        FUNC_DONE      = 3'd3,
        FUNC_TIMER     = 3'd4
    } func_t;

    // configuration register indexes
    localparam logic [1:0] CFG_CHIP_ID = 2'd0;
    localparam logic [1:0] CFG_RETRY   = 2'd1;
    localparam logic [1:0] CFG_SKIP    = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_CHIP_ID = 8'h34;
    localparam logic [7:0] RST_RETRY   = 8'd60;
    localparam logic [3:0] RST_SKIP    = 4'd1;

    // device register addresses and values
    localparam logic [7:0] DEV_PAGE      = 8'hFF;
    localparam logic [7:0] DEV_POWER     = 8'h14;
    localparam logic [7:0] DEV_CHIP_ID   = 8'hEE;
    localparam logic [7:0] DEV_MODE      = 8'h1B + 8'h07;
    localparam logic [7:0] DEV_INT_STAT  = 8'h06;
    localparam logic [7:0] DEV_GESTURE   = 8'h08 + 8'h02;
    localparam logic [7:0] VAL_ZERO      = 8'h00;
    localparam logic [7:0] VAL_SLEEP     = 8'h01;
    localparam logic [7:0] MODE_CONT     = 8'h00;
    localparam logic [7:0] MODE_WAKE     = 8'h02;
    localparam logic [7:0] INT_GEST_MASK = 8'h04;
    localparam logic [7:0] TAP_MASK      = 8'h03;
    localparam logic [7:0] ATTEMPT_MAX   = 8'hFF;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  slot;
        logic [7:0]  reg_addr;
        logic [2:0]  wlen;
        logic [7:0]  wval;
        logic [2:0]  rlen;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       eval;
        logic [1:0] emit_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] eval_cnt;
        logic [1:0] res_cnt;
    } sts_t;

    function automatic res_t make_res(kind_t k, logic [1:0] s, logic [7:0] ra,
                                      logic [2:0] wl, logic [7:0] wv, logic [2:0] rl);
        res_t r;
        r.kind     = k;
        r.slot     = s;
        r.reg_addr = ra;
        r.wlen     = wl;
        r.wval     = wv;
        r.rlen     = rl;
        return r;
    endfunction

    // slot index as it appears in the two-bit result field
    function automatic logic [1:0] slot_field(logic [SLOT_IDX_W-1:0] s);
        logic [SLOT_IDX_W+1:0] w;
        w = {2'b00, s};
        return w[1:0];
    endfunction

endpackage

@@ hw/rtl/twis_datapath.sv @@
// slot pool, sequencer state, configuration and result buffer
module twis_datapath
    import twis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic [23:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output logic [23:0] m_tdata,
    output logic [3:0]  m_tuser,
    output logic        m_tlast
);

    // configuration
    logic [7:0] chip_id_reg;
    logic [7:0] retry_reg;
    logic [3:0] skip_reg;

    // sequencer state
    logic [SLOT_COUNT-1:0] busy_reg, busy_next;
    step_t                 step_reg [SLOT_COUNT];
    step_t                 step_next [SLOT_COUNT];
    logic                  powered_reg, powered_next;
    logic [7:0]            attempt_reg, attempt_next;
    logic                  armed_reg, armed_next;

    // latched event
    logic [2:0] func_reg;
    logic [1:0] dslot_reg;
    logic [7:0] b0_reg;
    logic [7:0] b1_reg;

    // result buffer
    res_t       res_reg [RES_DEPTH];
    res_t       res_next [RES_DEPTH];
    logic [1:0] res_cnt_reg;
    logic [1:0] n;

    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [SLOT_EXT_W-1:0] dslot_ext;
    logic [SLOT_IDX_W-1:0] done_idx;
    logic                  done_ok;
    logic [7:0]            att_inc;
    res_t                  cur;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    // completed slot lookup
    assign dslot_ext = {{(SLOT_EXT_W-2){1'b0}}, dslot_reg};
    assign done_idx  = dslot_ext[SLOT_IDX_W-1:0];
    assign done_ok   = (dslot_ext < SLOT_EXT_W'(SLOT_COUNT)) && busy_reg[done_idx];
    assign att_inc   = (attempt_reg == ATTEMPT_MAX) ? attempt_reg : attempt_reg + 8'd1;

    // event evaluation
    always_comb begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        powered_next = powered_reg;
        attempt_next = attempt_reg;
        armed_next   = armed_reg;
        for (int i = 0; i < RES_DEPTH; i++) begin
            res_next[i] = '0;
        end
        n = 2'd0;
        unique case (func_t'(func_reg))
            FUNC_POWER_ON: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (busy_reg[i]) step_next[i] = STEP_CANCEL;
                end
                attempt_next = 8'd0;
                if (free_found) begin
                    busy_next[free_idx] = 1'b1;
                    step_next[free_idx] = STEP_EN0;
                    res_next[n] = make_res(KIND_WRITE, slot_field(free_idx), DEV_PAGE,
                                           3'd2, VAL_ZERO, 3'd0);
                    n = n + 2'd1;
                    powered_next = 1'b1;
                    res_next[n] = make_res(KIND_ON, 2'd0, 8'd0, 3'd0, 8'd0, 3'd0);
                    n = n + 2'd1;
                end else begin
                    res_next[n] = make_res(KIND_REFUSED, 2'd0, 8'd0, 3'd0, 8'd0, 3'd0);
                    n = n + 2'd1;
                end
            end
            FUNC_POWER_OFF: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (busy_reg[i]) step_next[i] = STEP_CANCEL;
                end
                if (armed_reg) begin
                    res_next[n] = make_res(KIND_CANCEL, 2'd0, 8'd0, 3'd0, 8'd0, 3'd0);
                    n = n + 2'd1;
                    armed_next = 1'b0;
                end
                if (free_found) begin
                    busy_next[free_idx] = 1'b1;
                    step_next[free_idx] = STEP_DIS0;
                    res_next[n] = make_res(KIND_WRITE, slot_field(free_idx), DEV_MODE,
                                           3'd4, MODE_CONT, 3'd0);
                    n = n + 2'd1;
                    powered_next = 1'b0;
                    res_next[n] = make_res(KIND_OFF, 2'd0, 8'd0, 3'd0, 8'd0, 3'd0);
                    n = n + 2'd1;
                end else begin
                    res_next[n] = make_res(KIND_REFUSED, 2'd0, 8'd0, 3'd0, 8'd0, 3'd0);
                    n = n + 2'd1;
                end
            end
            FUNC_TOUCH: begin
                if (powered_reg && free_found) begin
                    busy_next[free_idx] = 1'b1;
                    step_next[free_idx] = STEP_INT0;
                    res_next[n] = make_res(KIND_WRRD, slot_field(free_idx), DEV_INT_STAT,
                                           3'd1, 8'd0, 3'd2);
                    n = n + 2'd1;
                end
            end
            FUNC_DONE: begin
                if (done_ok) begin
                    unique case (step_reg[done_idx])
                        STEP_EN0: begin
                            if (free_found) begin
                                busy_next[free_idx] = 1'b1;
                                step_next[free_idx] = STEP_EN1;
                                res_next[n] = make_res(KIND_WRITE, slot_field(free_idx),
                                                       DEV_POWER, 3'd2, VAL_ZERO, 3'd0);
                                n = n + 2'd1;
                            end
                        end
                        STEP_EN1: begin
                            if (free_found) begin
                                busy_next[free_idx] = 1'b1;
                                step_next[free_idx] = STEP_EN2;
                                res_next[n] = make_res(KIND_WRRD, slot_field(free_idx),
                                                       DEV_CHIP_ID, 3'd1, 8'd0, 3'd1);
                                n = n + 2'd1;
                            end
                        end
                        STEP_EN2: begin
                            // identity check, with the first reads skipped
                            if ((attempt_reg < {4'b0000, skip_reg}) ||
                                (b0_reg != chip_id_reg)) begin
                                attempt_next = att_inc;
                                if (att_inc < retry_reg) begin
                                    armed_next  = 1'b1;
                                    res_next[n] = make_res(KIND_TIMER, 2'd0, 8'd0, 3'd0,
                                                           8'd0, 3'd0);
                                end else begin
                                    res_next[n] = make_res(KIND_GAVEUP, 2'd0, 8'd0, 3'd0,
                                                           8'd0, 3'd0);
                                end
                                n = n + 2'd1;
                            end else if (free_found) begin
                                busy_next[free_idx] = 1'b1;
                                step_next[free_idx] = STEP_IDLE;
                                res_next[n] = make_res(KIND_WRITE, slot_field(free_idx),
                                                       DEV_MODE, 3'd4, MODE_WAKE, 3'd0);
                                n = n + 2'd1;
                            end
                        end
                        STEP_DIS0: begin
                            if (free_found) begin
                                busy_next[free_idx] = 1'b1;
                                step_next[free_idx] = STEP_IDLE;
                                res_next[n] = make_res(KIND_WRITE, slot_field(free_idx),
                                                       DEV_POWER, 3'd2, VAL_SLEEP, 3'd0);
                                n = n + 2'd1;
                            end
                        end
                        STEP_INT0: begin
                            if (((b1_reg & INT_GEST_MASK) != 8'd0) && free_found) begin
                                busy_next[free_idx] = 1'b1;
                                step_next[free_idx] = STEP_INT1;
                                res_next[n] = make_res(KIND_WRRD, slot_field(free_idx),
                                                       DEV_GESTURE, 3'd1, 8'd0, 3'd5);
                                n = n + 2'd1;
                            end
                        end
                        STEP_INT1: begin
                            if ((b0_reg & TAP_MASK) != 8'd0) begin
                                res_next[n] = make_res(KIND_TAP, 2'd0, 8'd0, 3'd0,
                                                       8'd0, 3'd0);
                                n = n + 2'd1;
                            end
                        end
                        default: begin
                            // idle or cancelled slot: only freed
                        end
                    endcase
                    busy_next[done_idx] = 1'b0;
                end
            end
            FUNC_TIMER: begin
                armed_next = 1'b0;
                if (powered_reg && free_found) begin
                    busy_next[free_idx] = 1'b1;
                    step_next[free_idx] = STEP_EN0;
                    res_next[n] = make_res(KIND_WRITE, slot_field(free_idx), DEV_PAGE,
                                           3'd2, VAL_ZERO, 3'd0);
                    n = n + 2'd1;
                end
            end
            default: begin
                // unknown event code: no effect
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_id_reg <= RST_CHIP_ID;
            retry_reg   <= RST_RETRY;
            skip_reg    <= RST_SKIP;
            busy_reg    <= '0;
            powered_reg <= 1'b0;
            attempt_reg <= 8'd0;
            armed_reg   <= 1'b0;
            res_cnt_reg <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_CHIP_ID: chip_id_reg <= cfg_wdata;
                    CFG_RETRY:   retry_reg   <= cfg_wdata;
                    CFG_SKIP:    skip_reg    <= cfg_wdata[3:0];
                    default: begin
                        // index beyond the register list
                    end
                endcase
            end
            if (cmd.eval) begin
                busy_reg    <= busy_next;
                powered_reg <= powered_next;
                attempt_reg <= attempt_next;
                armed_reg   <= armed_next;
                res_cnt_reg <= n;
            end
        end
    end

    // payload: event latch, slot steps, results
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg  <= s_tuser;
            dslot_reg <= s_tdata[1:0];
            b0_reg    <= s_tdata[9:2];
            b1_reg    <= s_tdata[17:10];
        end
        if (cmd.eval) begin
            step_reg <= step_next;
            res_reg  <= res_next;
        end
    end

    // status back to the controller
    assign sts.eval_cnt = n;
    assign sts.res_cnt  = res_cnt_reg;

    // result presented on the output channel
    assign cur     = res_reg[cmd.emit_idx];
    assign m_tdata = {cur.rlen, cur.wval, cur.wlen, cur.reg_addr, cur.slot};
    assign m_tuser = cur.kind;
    assign m_tlast = (cmd.emit_idx == (res_cnt_reg - 2'd1));

endmodule

@@ hw/rtl/twis_controller.sv @@
// controller state machine: accept, evaluate, deliver results
module twis_controller
    import twis_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    state_t     state_reg;
    logic [1:0] idx_reg;

    // state and result index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    idx_reg   <= 2'd0;
                    state_reg <= (sts.eval_cnt != 2'd0) ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (idx_reg == (sts.res_cnt - 2'd1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // handshake and commands
    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = (state_reg == ST_EMIT);
    assign cmd.latch    = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.eval     = (state_reg == ST_EVAL);
    assign cmd.emit_idx = idx_reg;

endmodule

@@ hw/rtl/touch_wake_i2c_sequencer.sv @@
// top level of the touch wake i2c sequencer
// order: a request is taken in the idle state, evaluated in the next cycle, and its
// first result is shown in the cycle after that; results follow one per cycle while
// m_tready is high; with n results (0 to 3) per request, a new request is taken only
// after the last one is delivered, set by the evaluate step and the single result port
// reset: synchronous active-low aresetn frees all slots, powers off, clears the
// attempt count and timer flag, and loads the configuration reset values
module touch_wake_i2c_sequencer
    import twis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // done_slot[1:0], read_first[9:2], read_second[17:10]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // slot_used[1:0], reg_addr[9:2], write_len[12:10],
                                   // write_value[20:13], read_len[23:21]
    output logic [3:0]  m_tuser,   // kind[3:0]
    output logic        m_tlast
);

    cmd_t cmd;
    sts_t sts;

    twis_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    twis_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hw/rtl/twis_checker.sv @@
// port-level checks of the sequencer, bound to the top level
module twis_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // one request at a time: never taking a request while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // a taken request is evaluated before another is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a request was taken");

    // the final result frees the block for the next request
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after the final result");

    // a stalled result holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind touch_wake_i2c_sequencer twis_checker u_twis_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ bench/tb_touch_wake_i2c_sequencer.sv @@
// self-checking testbench of the touch wake i2c sequencer
module tb_touch_wake_i2c_sequencer;
    import twis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one result as seen on the master side
    typedef struct packed {
        kind_t      kind;
        logic [1:0] slot;
        logic [7:0] reg_addr;
        logic [2:0] wlen;
        logic [7:0] wval;
        logic [2:0] rlen;
        logic       last;
    } i2c_out_t;

    // one row of the directed plan; typed rows carry their own results
    typedef struct packed {
        logic [2:0]         func;
        logic [1:0]         slot;
        logic [7:0]         rd0;
        logic [7:0]         rd1;
        logic               typed;
        logic [1:0]         n;
        i2c_out_t [2:0]     res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // done_slot[1:0], read_first[9:2], read_second[17:10]
    logic [2:0]  s_tuser = '0;   // func[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // slot_used[1:0], reg_addr[9:2], write_len[12:10],
                                 // write_value[20:13], read_len[23:21]
    logic [3:0]  m_tuser;        // kind[3:0]
    logic        m_tlast;

    touch_wake_i2c_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // sequencer state as the block should hold it
    logic       pool_busy [SLOT_COUNT];
    step_t      pool_step [SLOT_COUNT];
    logic       is_powered;
    logic [7:0] tries;
    logic       wake_timer_on;
    logic [7:0] cfg_chip;
    logic [7:0] cfg_retry;
    logic [3:0] cfg_skip;

    i2c_out_t   event_out [$];   // results of the request being predicted
    i2c_out_t   cmds_due [$];    // results the block still owes
    i2c_out_t   typed_out [$];
    logic       typed_row = 1'b0;

    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         hold_asks = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    logic       failed = 1'b0;
    int         lost_results = 0;

    stim_row_t  plan [$];

    function automatic i2c_out_t out_item(kind_t k, logic [1:0] s, logic [7:0] ra,
                                          logic [2:0] wl, logic [7:0] wv, logic [2:0] rl,
                                          logic lst);
        i2c_out_t o;
        o.kind     = k;
        o.slot     = s;
        o.reg_addr = ra;
        o.wlen     = wl;
        o.wval     = wv;
        o.rlen     = rl;
        o.last     = lst;
        return o;
    endfunction

    function automatic void note(kind_t k, int s, logic [7:0] ra, logic [2:0] wl,
                                 logic [7:0] wv, logic [2:0] rl);
        event_out.push_back(out_item(k, 2'(s), ra, wl, wv, rl, 1'b0));
    endfunction

    function automatic void note_flag(kind_t k);
        note(k, 0, 8'h00, 3'd0, 8'h00, 3'd0);
    endfunction

    // first free slot, or -1 when the pool is full
    function automatic int claim_slot(step_t st);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!pool_busy[i]) begin
                pool_busy[i] = 1'b1;
                pool_step[i] = st;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic queue_write(logic [7:0] ra, logic [7:0] v, step_t st);
        int s;
        s = claim_slot(st);
        if (s < 0) return 1'b0;
        note(KIND_WRITE, s, ra, 3'd2, v, 3'd0);
        return 1'b1;
    endfunction

    // four-byte reporting mode write
    function automatic logic queue_mode(logic [7:0] v, step_t st);
        int s;
        s = claim_slot(st);
        if (s < 0) return 1'b0;
        note(KIND_WRITE, s, DEV_MODE, 3'd4, v, 3'd0);
        return 1'b1;
    endfunction

    function automatic void queue_wrrd(logic [7:0] ra, logic [2:0] rl, step_t st);
        int s;
        s = claim_slot(st);
        if (s >= 0) note(KIND_WRRD, s, ra, 3'd1, 8'h00, rl);
    endfunction

    // power on or off: outstanding transfers are abandoned first
    function automatic void switch_power(logic on);
        logic ok;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (pool_busy[i]) pool_step[i] = STEP_CANCEL;
        if (on) begin
            tries = 8'd0;
            ok = queue_write(DEV_PAGE, VAL_ZERO, STEP_EN0);
        end else begin
            if (wake_timer_on) begin
                note_flag(KIND_CANCEL);
                wake_timer_on = 1'b0;
            end
            ok = queue_mode(MODE_CONT, STEP_DIS0);
        end
        if (ok) begin
            is_powered = on;
            if (on) note_flag(KIND_ON);
            else note_flag(KIND_OFF);
        end else begin
            note_flag(KIND_REFUSED);
        end
    endfunction

    // completion of a busy slot moves its chain on
    function automatic void finish_slot(int s, logic [7:0] a, logic [7:0] b);
        case (pool_step[s])
            STEP_EN0: void'(queue_write(DEV_POWER, VAL_ZERO, STEP_EN1));
            STEP_EN1: queue_wrrd(DEV_CHIP_ID, 3'd1, STEP_EN2);
            STEP_EN2: begin
                if (tries < {4'd0, cfg_skip} || a != cfg_chip) begin
                    if (tries != 8'hFF) tries = tries + 8'd1;
                    if (tries < cfg_retry) begin
                        wake_timer_on = 1'b1;
                        note_flag(KIND_TIMER);
                    end else begin
                        note_flag(KIND_GAVEUP);
                    end
                end else begin
                    void'(queue_mode(MODE_WAKE, STEP_IDLE));
                end
            end
            STEP_DIS0: void'(queue_write(DEV_POWER, VAL_SLEEP, STEP_IDLE));
            STEP_INT0: if (b[2]) queue_wrrd(DEV_GESTURE, 3'd5, STEP_INT1);
            STEP_INT1: if (a[1:0] != 2'b00) note_flag(KIND_TAP);
            default: ;
        endcase
        pool_busy[s] = 1'b0;
    endfunction

    // all results that one accepted request causes
    function automatic void sequence_event(logic [2:0] f, logic [1:0] s, logic [7:0] a,
                                           logic [7:0] b);
        i2c_out_t t;
        event_out.delete();
        case (f)
            FUNC_POWER_ON:  switch_power(1'b1);
            FUNC_POWER_OFF: switch_power(1'b0);
            FUNC_TOUCH:     if (is_powered) queue_wrrd(DEV_INT_STAT, 3'd2, STEP_INT0);
            FUNC_DONE:      if (pool_busy[s]) finish_slot(int'(s), a, b);
            FUNC_TIMER: begin
                wake_timer_on = 1'b0;
                if (is_powered) void'(queue_write(DEV_PAGE, VAL_ZERO, STEP_EN0));
            end
            default: ;
        endcase
        if (event_out.size() > 0) begin
            t = event_out.pop_back();
            t.last = 1'b1;
            event_out.push_back(t);
        end
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            pool_busy[i] = 1'b0;
            pool_step[i] = STEP_EN0;
        end
        is_powered    = 1'b0;
        tries         = 8'd0;
        wake_timer_on = 1'b0;
        cfg_chip      = 8'h34;
        cfg_retry     = 8'd60;
        cfg_skip      = 4'd1;
    endfunction

    function automatic stim_row_t row(logic [2:0] f, logic [1:0] s, logic [7:0] a,
                                      logic [7:0] b, logic typed);
        stim_row_t r;
        r       = '0;
        r.func  = f;
        r.slot  = s;
        r.rd0   = a;
        r.rd1   = b;
        r.typed = typed;
        return r;
    endfunction

    function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            failed = 1'b1;
        end
    endfunction

    // offer one request, predict it on acceptance, then maybe idle
    task automatic offer(input logic [2:0] f, input logic [1:0] s, input logic [7:0] a,
                         input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {6'd0, b, a, s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sequence_event(f, s, a, b);
        if (typed_row) begin
            foreach (typed_out[i]) cmds_due.push_back(typed_out[i]);
        end else begin
            foreach (event_out[i]) cmds_due.push_back(event_out[i]);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // sender quiet until every owed result has come, then let the block settle
    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (cmds_due.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        if (cmds_due.size() != 0) begin
            $display("%0t: %0d results expected, none came", $time, cmds_due.size());
            lost_results += cmds_due.size();
            cmds_due.delete();
        end
        repeat (8) @(posedge aclk);
    endtask

    // write all three registers back to back, only while the block is idle
    task automatic load_config(input logic [7:0] chip, input logic [7:0] retry,
                               input logic [3:0] skip);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CHIP_ID;
        cfg_wdata <= chip;
        @(posedge aclk);
        cfg_index <= CFG_RETRY;
        cfg_wdata <= retry;
        @(posedge aclk);
        cfg_index <= CFG_SKIP;
        cfg_wdata <= {4'd0, skip};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_chip  = chip;
        cfg_retry = retry;
        cfg_skip  = skip;
    endtask

    // random requests, up to half of them completions of slots that are really busy
    task automatic random_events(input int count);
        int n;
        int r;
        int busy_list [$];
        logic [2:0] f;
        logic [1:0] s;
        logic [7:0] a;
        logic [7:0] b;
        n = 0;
        while (n < count) begin
            busy_list.delete();
            for (int i = 0; i < SLOT_COUNT; i++)
                if (pool_busy[i]) busy_list.push_back(i);
            r = $urandom_range(99);
            s = 2'($urandom);
            a = 8'($urandom);
            b = 8'($urandom);
            if (r < 50 && busy_list.size() > 0) begin
                f = FUNC_DONE;
                s = 2'(busy_list[$urandom_range(busy_list.size() - 1)]);
                if (pool_step[s] == STEP_EN2 && $urandom_range(1) != 0) a = cfg_chip;
                if (pool_step[s] == STEP_INT0 && $urandom_range(2) != 0) b[2] = 1'b1;
            end else if (r < 64) begin
                f = FUNC_TOUCH;
            end else if (r < 76) begin
                f = FUNC_TIMER;
            end else if (r < 84) begin
                f = FUNC_POWER_ON;
            end else if (r < 90) begin
                f = FUNC_POWER_OFF;
            end else if (r < 95) begin
                f = FUNC_DONE;
            end else begin
                f = 3'($urandom_range(5, 7));
            end
            if (f <= FUNC_TIMER) n++;
            offer(f, s, a, b);
        end
    endtask

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each result with the oldest one owed
    always @(posedge aclk) begin : result_check
        i2c_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (cmds_due.size() == 0) begin
                $display("%0t: result kind %0h expected none", $time, m_tuser);
                failed = 1'b1;
            end else begin
                want = cmds_due.pop_front();
                check_field("kind", 8'(want.kind), 8'(m_tuser));
                check_field("slot_used", 8'(want.slot), 8'(m_tdata[1:0]));
                check_field("reg_addr", want.reg_addr, m_tdata[9:2]);
                check_field("write_len", 8'(want.wlen), 8'(m_tdata[12:10]));
                check_field("write_value", want.wval, m_tdata[20:13]);
                check_field("read_len", 8'(want.rlen), 8'(m_tdata[23:21]));
                check_field("last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    initial begin
        stim_row_t r;
        model_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed plan: quiet cases, both chains, full pool, refusal, double tap
        plan.push_back(row(FUNC_TOUCH, 2'd0, 8'h00, 8'h00, 1'b1));
        plan.push_back(row(FUNC_TIMER, 2'd1, 8'hFF, 8'hFF, 1'b1));
        plan.push_back(row(FUNC_DONE, 2'd3, 8'hFF, 8'hFF, 1'b1));
        plan.push_back(row(3'd7, 2'd2, 8'h55, 8'hAA, 1'b1));
        r = row(FUNC_POWER_ON, 2'd0, 8'h00, 8'h00, 1'b1);
        r.n = 2'd2;
        r.res[0] = out_item(KIND_WRITE, 2'd0, 8'hFF, 3'd2, 8'h00, 3'd0, 1'b0);
        r.res[1] = out_item(KIND_ON, 2'd0, 8'h00, 3'd0, 8'h00, 3'd0, 1'b1);
        plan.push_back(r);
        plan.push_back(row(FUNC_DONE, 2'd0, 8'h00, 8'h00, 1'b0));
        plan.push_back(row(FUNC_DONE, 2'd1, 8'hFF, 8'h00, 1'b0));
        // identity matches but falls within the skipped reads
        plan.push_back(row(FUNC_DONE, 2'd0, 8'h34, 8'h00, 1'b0));
        // fill the pool with interrupt reads
        plan.push_back(row(FUNC_TOUCH, 2'd0, 8'h12, 8'h34, 1'b0));
        plan.push_back(row(FUNC_TOUCH, 2'd1, 8'h56, 8'h78, 1'b0));
        plan.push_back(row(FUNC_TOUCH, 2'd2, 8'h9A, 8'hBC, 1'b0));
        plan.push_back(row(FUNC_TOUCH, 2'd3, 8'hDE, 8'hF0, 1'b0));
        // power off with the timer armed and no slot: cancel then refusal
        r = row(FUNC_POWER_OFF, 2'd0, 8'h00, 8'h00, 1'b1);
        r.n = 2'd2;
        r.res[0] = out_item(KIND_CANCEL, 2'd0, 8'h00, 3'd0, 8'h00, 3'd0, 1'b0);
        r.res[1] = out_item(KIND_REFUSED, 2'd0, 8'h00, 3'd0, 8'h00, 3'd0, 1'b1);
        plan.push_back(r);
        plan.push_back(row(FUNC_TIMER, 2'd0, 8'h00, 8'h00, 1'b0));
        // cancelled slots are only freed
        plan.push_back(row(FUNC_DONE, 2'd2, 8'hFF, 8'hFF, 1'b0));
        plan.push_back(row(FUNC_DONE, 2'd0, 8'h03, 8'h04, 1'b0));
        plan.push_back(row(FUNC_DONE, 2'd1, 8'h00, 8'h00, 1'b0));
        plan.push_back(row(FUNC_DONE, 2'd3, 8'h03, 8'hFF, 1'b0));
        // disable chain
        plan.push_back(row(FUNC_POWER_OFF, 2'd1, 8'h00, 8'h00, 1'b0));
        plan.push_back(row(FUNC_DONE, 2'd0, 8'h00, 8'h00, 1'b0));
        // gesture read and double tap
        plan.push_back(row(FUNC_POWER_ON, 2'd2, 8'hAA, 8'h55, 1'b0));
        plan.push_back(row(FUNC_TOUCH, 2'd3, 8'h00, 8'h00, 1'b0));
        plan.push_back(row(FUNC_DONE, 2'd2, 8'h00, 8'h04, 1'b0));
        plan.push_back(row(FUNC_DONE, 2'd3, 8'hFF, 8'h00, 1'b0));

        foreach (plan[i]) begin
            typed_out.delete();
            typed_row = plan[i].typed;
            for (int k = 0; k < int'(plan[i].n); k++) typed_out.push_back(plan[i].res[k]);
            offer(plan[i].func, plan[i].slot, plan[i].rd0, plan[i].rd1);
        end
        typed_row = 1'b0;
        drain();

        // random phases, each with its own idling and register setting
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    load_config(8'h00, 8'd1, 4'd0);
                end
                1: begin
                    send_idle_pct = 62;
                    stall_pct = 0;
                    load_config(8'hFF, 8'd255, 4'd15);
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 62;
                    load_config(8'($urandom), 8'($urandom_range(2, 5)),
                                4'($urandom_range(0, 2)));
                end
                default: begin
                    send_idle_pct = 14;
                    stall_pct = 14;
                    load_config(8'h34, 8'd60, 4'd1);
                end
            endcase
            if (ph == 0) begin
                // receiver holds off while power requests keep coming
                hold_asks++;
                for (int k = 0; k < 10; k++)
                    offer((k % 2 == 0) ? FUNC_POWER_ON : FUNC_POWER_OFF, 2'($urandom),
                          8'($urandom), 8'($urandom));
                drain();
            end
            random_events(18);
            drain();
        end

        if (!failed && lost_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
